/* hw/rtl/rgba_to_bottom_up_bgr_dib_macros.svh */
// Assertion macros shared by the RTL. Each use expects clk and rst in scope.
`ifndef RGBA_TO_BOTTOM_UP_BGR_DIB_MACROS_SVH
`define RGBA_TO_BOTTOM_UP_BGR_DIB_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define R2DIB_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("r2dib: assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define R2DIB_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("r2dib: sequence assertion failed");

`else

`define R2DIB_ASSERT(label, cond)
`define R2DIB_ASSERT_NEXT(label, trig, cond)

`endif

`endif

/* hw/rtl/r2dib_pkg.sv */
package r2dib_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int STRIDE_W = $clog2(3 * MAX_WIDTH + 4);

  localparam int REG_W       = 13;
  localparam int REG_INDEX_W = 2;
  localparam int CHAN_W      = 8;
  localparam int OFFSET_W    = 26;

  localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH  = REG_INDEX_W'(0);
  localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT = REG_INDEX_W'(1);

  // Effective width minus one: zero reads as one, oversize saturates.
  function automatic logic [COL_W-1:0] width_m1_of(input logic [REG_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_WIDTH) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(v - REG_W'(1));
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] height_m1_of(input logic [REG_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_HEIGHT) begin
      r = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      r = ROW_W'(v - REG_W'(1));
    end
    return r;
  endfunction

  // Row stride in bytes: three bytes a pixel, rounded up to a multiple of four.
  function automatic logic [STRIDE_W-1:0] stride_of(input logic [COL_W-1:0] wm1);
    logic [STRIDE_W-1:0] w;
    logic [STRIDE_W-1:0] s;
    w = STRIDE_W'(wm1) + STRIDE_W'(1);
    s = (w << 1) + w + STRIDE_W'(3);
    return {s[STRIDE_W-1:2], 2'b00};
  endfunction

endpackage

/* hw/rtl/r2dib_pixel_if.sv */
interface r2dib_pixel_if;
  import r2dib_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] alpha_in;

  modport source (
    output valid, red_in, green_in, blue_in, alpha_in,
    input  ready
  );

  modport sink (
    input  valid, red_in, green_in, blue_in, alpha_in,
    output ready
  );
endinterface

/* hw/rtl/r2dib_result_if.sv */
interface r2dib_result_if;
  import r2dib_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] byte_offset;
  logic [CHAN_W-1:0]   blue_out;
  logic [CHAN_W-1:0]   green_out;
  logic [CHAN_W-1:0]   red_out;
  logic                frame_last;

  modport source (
    output valid, byte_offset, blue_out, green_out, red_out, frame_last,
    input  ready
  );

  modport sink (
    input  valid, byte_offset, blue_out, green_out, red_out, frame_last,
    output ready
  );
endinterface

/* hw/rtl/rgba_to_bottom_up_bgr_dib.sv */
// RGBA to bottom-up BGR DIB converter. Feed RGBA pixels in top-down raster order;
// each beat on the result channel carries the pixel flattened onto white, as
// blue, green and red bytes, with the byte offset of its blue byte in a bottom-up
// 24-bit pixel array (row stride 3*width rounded up to four bytes) and a flag on
// the last pixel of the frame. One pixel is taken every clock cycle when the
// result side keeps up; the input register and the result register sit either
// side of the blend-and-divide logic. Writing either size register restarts the
// frame. A size of zero acts as one and sizes above 4096 saturate. Row padding
// bytes are not produced: the consumer zero-fills.
`include "rgba_to_bottom_up_bgr_dib_macros.svh"

module rgba_to_bottom_up_bgr_dib (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [r2dib_pkg::REG_INDEX_W-1:0] write_index,
  input  logic [r2dib_pkg::REG_W-1:0]       write_data,
  r2dib_pixel_if.sink                      pixel,
  r2dib_result_if.source                   result
);
  import r2dib_pkg::*;

  // Frame geometry, held in effective form so that no clamp sits in the pixel path.
  logic [COL_W-1:0]    width_m1;
  logic [ROW_W-1:0]    height_m1;
  logic [STRIDE_W-1:0] stride;
  logic [OFFSET_W-1:0] restart_base;

  logic [COL_W-1:0]    width_m1_next;
  logic [ROW_W-1:0]    height_m1_next;
  logic [STRIDE_W-1:0] stride_next;
  logic [OFFSET_W-1:0] restart_base_next;
  logic                cfg_hit;

  // Raster position of the next pixel.
  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [OFFSET_W-1:0] row_base_offset;

  // Input register stage.
  logic                s1_valid;
  logic [CHAN_W-1:0]   s1_red;
  logic [CHAN_W-1:0]   s1_green;
  logic [CHAN_W-1:0]   s1_blue;
  logic [CHAN_W-1:0]   s1_alpha;
  logic [OFFSET_W-1:0] s1_offset;
  logic                s1_last;

  // Result register stage.
  logic                out_valid;
  logic [OFFSET_W-1:0] out_offset;
  logic [CHAN_W-1:0]   out_blue;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_red;
  logic                out_last;

  logic s1_ready;
  logic s2_ready;
  logic in_beat;
  logic last_col;
  logic last_row;
  logic [OFFSET_W-1:0] pix_offset;

  // Blend one channel onto white and divide by 255 with rounding. The
  // numerator stays below 65535, where (x + (x >> 8) + 1) >> 8 equals x / 255.
  function automatic logic [CHAN_W-1:0] flatten(input logic [CHAN_W-1:0] c,
                                                input logic [CHAN_W-1:0] a);
    logic [16:0] x;
    logic [16:0] q;
    x = 17'(c) * 17'(a) + 17'(8'd255) * 17'(8'd255 - a) + 17'd127;
    q = (x + (x >> 8) + 17'd1) >> 8;
    return q[CHAN_W-1:0];
  endfunction

  // Decode a register write into the new geometry. The stride multiply lands
  // in a register, so a pixel in the very next cycle sees the new frame.
  always_comb begin
    cfg_hit        = 1'b0;
    width_m1_next  = width_m1;
    height_m1_next = height_m1;
    if (write_enable) begin
      unique case (write_index)
        REG_IMAGE_WIDTH: begin
          cfg_hit       = 1'b1;
          width_m1_next = width_m1_of(write_data);
        end
        REG_IMAGE_HEIGHT: begin
          cfg_hit        = 1'b1;
          height_m1_next = height_m1_of(write_data);
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    stride_next       = stride_of(width_m1_next);
    restart_base_next = OFFSET_W'(height_m1_next) * OFFSET_W'(stride_next);
  end

  // Handshake: each stage takes a beat when empty or when the next one drains.
  assign s2_ready    = !out_valid || result.ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign pixel.ready = s1_ready;
  assign in_beat     = pixel.valid && s1_ready;

  assign last_col   = column_count >= width_m1;
  assign last_row   = row_count >= height_m1;
  assign pix_offset = row_base_offset + OFFSET_W'({column_count, 1'b0})
                      + OFFSET_W'(column_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1        <= '0;
      height_m1       <= '0;
      stride          <= STRIDE_W'(4);
      restart_base    <= '0;
      column_count    <= '0;
      row_count       <= '0;
      row_base_offset <= '0;
    end else if (cfg_hit) begin
      // Restart the frame on any size write.
      width_m1        <= width_m1_next;
      height_m1       <= height_m1_next;
      stride          <= stride_next;
      restart_base    <= restart_base_next;
      column_count    <= '0;
      row_count       <= '0;
      row_base_offset <= restart_base_next;
    end else if (in_beat) begin
      if (!last_col) begin
        column_count <= column_count + COL_W'(1);
      end else if (!last_row) begin
        // Step one output row up the bottom-up array.
        column_count    <= '0;
        row_count       <= row_count + ROW_W'(1);
        row_base_offset <= row_base_offset - OFFSET_W'(stride);
      end else begin
        // Wrap for the next frame.
        column_count    <= '0;
        row_count       <= '0;
        row_base_offset <= restart_base;
      end
    end
  end

  // Valid flags of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pixel.valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers: capture on a beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_red    <= pixel.red_in;
      s1_green  <= pixel.green_in;
      s1_blue   <= pixel.blue_in;
      s1_alpha  <= pixel.alpha_in;
      s1_offset <= pix_offset;
      s1_last   <= last_col && last_row;
    end
    if (s1_valid && s2_ready) begin
      out_offset <= s1_offset;
      out_blue   <= flatten(s1_blue, s1_alpha);
      out_green  <= flatten(s1_green, s1_alpha);
      out_red    <= flatten(s1_red, s1_alpha);
      out_last   <= s1_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.byte_offset = out_offset;
  assign result.blue_out    = out_blue;
  assign result.green_out   = out_green;
  assign result.red_out     = out_red;
  assign result.frame_last  = out_last;

  `R2DIB_ASSERT(a_col_in_range, column_count <= width_m1)
  `R2DIB_ASSERT(a_row_in_range, row_count <= height_m1)
  `R2DIB_ASSERT(a_top_row_base, (row_count != '0) || (row_base_offset == restart_base))
  `R2DIB_ASSERT_NEXT(a_wrap_clears, in_beat && last_col && last_row,
                     column_count == '0 && row_count == '0)
  `R2DIB_ASSERT_NEXT(a_s1_holds, s1_valid && !s2_ready, s1_valid && $stable(s1_offset))

endmodule

/* sim/r2dib_stream_check.sv */
`timescale 1ns / 1ps

module r2dib_stream_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [r2dib_pkg::REG_INDEX_W-1:0] write_index,
  input  logic [r2dib_pkg::REG_W-1:0]       write_data,
  r2dib_pixel_if                            pixel,
  r2dib_result_if                           result,
  output int                                fail_count,
  output int                                pending
);
  import r2dib_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   red;
    logic                frame_last;
  } dib_beat_t;

  dib_beat_t dib_beats_due[$];
  dib_beat_t oldest;

  logic [REG_W-1:0]    width_reg;
  logic [REG_W-1:0]    height_reg;
  logic [COL_W-1:0]    col_next;
  logic [ROW_W-1:0]    row_next;
  logic [OFFSET_W-1:0] row_base;

  int mismatches = 0;
  int due_count  = 0;
  int beat_index = 0;

  assign fail_count = mismatches;
  assign pending    = due_count;

  function automatic int unsigned clamp_size(input logic [REG_W-1:0] v, input int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned stride_bytes(input int unsigned w);
    return (w * 3 + 3) & ~32'd3;
  endfunction

  function automatic logic [CHAN_W-1:0] flatten_on_white(input logic [CHAN_W-1:0] c,
                                                         input logic [CHAN_W-1:0] a);
    int unsigned ci;
    int unsigned ai;
    ci = c;
    ai = a;
    return CHAN_W'((ci * ai + 255 * (255 - ai) + 127) / 255);
  endfunction

  // Start the frame over: top-down row 0 lands in the last row of the output array.
  task automatic restart_frame();
    col_next = '0;
    row_next = '0;
    row_base = OFFSET_W'((clamp_size(height_reg, MAX_HEIGHT) - 1) *
                         stride_bytes(clamp_size(width_reg, MAX_WIDTH)));
  endtask

  task automatic predict_pixel(input logic [CHAN_W-1:0] r, g, b, a);
    int unsigned w;
    int unsigned h;
    bit          last_col;
    bit          last_row;
    dib_beat_t   beat;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    last_col = (int'(col_next) + 1 >= w);
    last_row = (int'(row_next) + 1 >= h);
    beat.byte_offset = OFFSET_W'(row_base + 3 * col_next);
    beat.blue        = flatten_on_white(b, a);
    beat.green       = flatten_on_white(g, a);
    beat.red         = flatten_on_white(r, a);
    beat.frame_last  = last_col && last_row;
    dib_beats_due.push_back(beat);
    if (!last_col) begin
      col_next = col_next + 1'b1;
    end else if (!last_row) begin
      col_next = '0;
      row_next = row_next + 1'b1;
      row_base = OFFSET_W'(row_base - stride_bytes(w));
    end else begin
      restart_frame();
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d: %s is %0h, expected %0h", beat_index, name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = REG_W'(1);
      height_reg = REG_W'(1);
      restart_frame();
      dib_beats_due.delete();
    end else begin
      if (write_enable) begin
        if (write_index == REG_IMAGE_WIDTH) begin
          width_reg = write_data;
          restart_frame();
        end else if (write_index == REG_IMAGE_HEIGHT) begin
          height_reg = write_data;
          restart_frame();
        end
      end
      if (pixel.valid && pixel.ready)
        predict_pixel(pixel.red_in, pixel.green_in, pixel.blue_in, pixel.alpha_in);
      if (result.valid && result.ready) begin
        if (dib_beats_due.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with no pixel waiting for it", beat_index));
        end else begin
          oldest = dib_beats_due.pop_front();
          compare_field("byte_offset", 32'(result.byte_offset), 32'(oldest.byte_offset));
          compare_field("blue_out", 32'(result.blue_out), 32'(oldest.blue));
          compare_field("green_out", 32'(result.green_out), 32'(oldest.green));
          compare_field("red_out", 32'(result.red_out), 32'(oldest.red));
          compare_field("frame_last", 32'(result.frame_last), 32'(oldest.frame_last));
        end
        beat_index++;
      end
    end
    due_count <= dib_beats_due.size();
  end

endmodule

/* sim/tb_rgba_to_bottom_up_bgr_dib.sv */
`timescale 1ns / 1ps

module tb_rgba_to_bottom_up_bgr_dib;
  import r2dib_pkg::*;

  // Two register stages through the block.
  localparam int PIPE_LATENCY     = 2;
  localparam int RANDOM_ITEMS     = 700;
  // Both sides stop idling for roughly this many pixels at the end.
  localparam int QUIET_ITEMS      = 120;
  localparam int LONG_HOLD_CYCLES = 300;
  // Longest correct stretch with no beat is the long hold; allow well over that.
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int REG_DATA_MAX     = (1 << REG_W) - 1;

  // Indexes past the register list: the block must ignore writes to them.
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_LO = REG_INDEX_W'(2);
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_HI = REG_INDEX_W'(3);

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   write_enable;
  logic [REG_INDEX_W-1:0] write_index;
  logic [REG_W-1:0]       write_data;

  // Stimulus-side copy of the sizes, used only to pick pixel counts per phase.
  logic [REG_W-1:0] cur_w = REG_W'(1);
  logic [REG_W-1:0] cur_h = REG_W'(1);

  bit quiet     = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;
  int fail_count;
  int pending;

  r2dib_pixel_if  pix_if ();
  r2dib_result_if res_if ();

  rgba_to_bottom_up_bgr_dib uut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel        (pix_if),
    .result       (res_if)
  );

  r2dib_stream_check stream_check (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel        (pix_if),
    .result       (res_if),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly random channel levels, with the extremes pulled in often.
  function automatic logic [CHAN_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Sizes at, just under or past the limit, or zero.
  function automatic logic [REG_W-1:0] pick_large_size(input int unsigned maxv);
    case ($urandom_range(0, 3))
      0: return REG_W'(maxv);
      1: return REG_W'(maxv - $urandom_range(1, 3));
      2: return REG_W'($urandom_range(maxv + 1, REG_DATA_MAX));
      default: return '0;
    endcase
  endfunction

  function automatic int unsigned effective_size(input logic [REG_W-1:0] v,
                                                 input int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Offer one pixel and hold it until the block takes the beat. A gap drops
  // valid first; otherwise valid stays high straight into the next beat.
  task automatic offer_pixel(input logic [CHAN_W-1:0] r, g, b, a);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.red_in   <= r;
    pix_if.green_in <= g;
    pix_if.blue_in  <= b;
    pix_if.alpha_in <= a;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  // Stop offering and wait for every predicted beat to come out. Wait on the clock
  // first so that a beat accepted on the last edge is already counted.
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // One write per call, with the enable low again before the task returns so the
  // enable never falls and rises in the same step.
  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [REG_W-1:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    if (idx == REG_IMAGE_WIDTH) cur_w = data;
    else if (idx == REG_IMAGE_HEIGHT) cur_h = data;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: ready in random bursts, one long hold on request, and no
  // idling once the run goes quiet.
  initial begin : result_sink
    int span;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 8);
        res_if.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end else begin
        span = $urandom_range(1, 12);
        res_if.ready <= 1'b1;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no beat or write moves for too long.
  always @(posedge clk) begin
    if (rst || write_enable || (pix_if.valid && pix_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [REG_W-1:0] w_val;
    logic [REG_W-1:0] h_val;
    int unsigned      pixels_per_frame;
    int unsigned      n;
    int unsigned      random_sent;
    int unsigned      phase;

    rst             <= 1'b1;
    write_enable    <= 1'b0;
    write_index     <= REG_IMAGE_WIDTH;
    write_data      <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.red_in   <= '0;
    pix_if.green_in <= '0;
    pix_if.blue_in  <= '0;
    pix_if.alpha_in <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset size is one by one: every pixel closes a frame. Walk the alpha
    // extremes: transparent goes white, opaque passes the colour through.
    offer_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    offer_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
    offer_pixel(8'h00, 8'h00, 8'h00, 8'h80);
    offer_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80);
    offer_pixel(8'h55, 8'hAA, 8'h0F, 8'h01);
    offer_pixel(8'hAA, 8'h55, 8'hF0, 8'hFE);

    // Zero sizes behave as one.
    drain_results();
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    offer_pixel(pick_level(), pick_level(), pick_level(), pick_level());
    offer_pixel(pick_level(), pick_level(), pick_level(), pick_level());

    // All-ones sizes saturate to the maximum frame; start at the far row.
    drain_results();
    write_reg(REG_IMAGE_WIDTH, REG_W'(REG_DATA_MAX));
    write_reg(REG_IMAGE_HEIGHT, REG_W'(REG_DATA_MAX));
    repeat (3) offer_pixel(pick_level(), pick_level(), pick_level(), pick_level());

    // Writes past the register list must leave the frame where it is.
    drain_results();
    write_reg(REG_SPARE_LO, REG_W'(REG_DATA_MAX));
    write_reg(REG_SPARE_HI, '0);
    repeat (3) offer_pixel(pick_level(), pick_level(), pick_level(), pick_level());

    // A real write mid-frame restarts it. Width five pads each row by a byte.
    drain_results();
    write_reg(REG_IMAGE_WIDTH, REG_W'(5));
    write_reg(REG_IMAGE_HEIGHT, REG_W'(2));
    repeat (10) offer_pixel(pick_level(), pick_level(), pick_level(), pick_level());

    // Random phases: each picks sizes, writes some registers while idle and
    // streams whole frames plus a partial one. Huge frames get a short run.
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: begin
          w_val = pick_large_size(MAX_WIDTH);
          h_val = REG_W'($urandom_range(1, 6));
        end
        1: begin
          w_val = REG_W'($urandom_range(1, 9));
          h_val = pick_large_size(MAX_HEIGHT);
        end
        2: begin
          w_val = pick_large_size(MAX_WIDTH);
          h_val = pick_large_size(MAX_HEIGHT);
        end
        default: begin
          w_val = REG_W'($urandom_range(1, 9));
          h_val = REG_W'($urandom_range(1, 6));
        end
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_IMAGE_WIDTH, w_val);
        1: write_reg(REG_IMAGE_HEIGHT, h_val);
        2: begin
          write_reg(REG_IMAGE_HEIGHT, h_val);
          write_reg(REG_IMAGE_WIDTH, w_val);
        end
        3: write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                     REG_W'($urandom_range(0, REG_DATA_MAX)));
        default: begin
          write_reg(REG_IMAGE_WIDTH, w_val);
          write_reg(REG_IMAGE_HEIGHT, h_val);
        end
      endcase

      pixels_per_frame = effective_size(cur_w, MAX_WIDTH) * effective_size(cur_h, MAX_HEIGHT);
      if (pixels_per_frame > 64)
        n = $urandom_range(5, 24);
      else
        n = pixels_per_frame * $urandom_range(1, 3) + $urandom_range(0, pixels_per_frame - 1);

      // Hold the result side off for a long stretch while pixels keep coming,
      // so the block fills and pushes back on its input.
      if (phase == 2) begin
        n += 40;
        long_hold = 1'b1;
      end

      for (int i = 0; i < n; i++) begin
        // Pause the source mid-phase until every beat is out.
        if (phase == 5 && i == n / 2) drain_results();
        offer_pixel(pick_level(), pick_level(), pick_level(), pick_level());
      end
      random_sent += n;
      if (random_sent + QUIET_ITEMS >= RANDOM_ITEMS) quiet = 1'b1;
      phase++;
    end

    // Flush, then wait on past the pipeline depth to show any stray beat.
    drain_results();
    repeat (PIPE_LATENCY + 6) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
